### hdl/atan2_polynomial_approx_unit_defines.svh
// Assertion macros for the atan2 polynomial approximation unit.
`ifndef ATAN2_POLYNOMIAL_APPROX_UNIT_DEFINES_SVH
`define ATAN2_POLYNOMIAL_APPROX_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define A2P_CHK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define A2P_CHK_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/a2p_pkg.sv
// Types and constants for the atan2 polynomial approximation unit.
package a2p_pkg;

  localparam int COORD_WIDTH     = 16;
  localparam int RATIO_FRAC_BITS = 15;

  localparam int ANGLE_W    = 16;
  localparam int ANGLE_FRAC = 13;
  localparam int COEF_FRAC  = 30;
  localparam int COEF_W     = 30;

  localparam int MAG_W   = COORD_WIDTH;
  localparam int RATIO_W = RATIO_FRAC_BITS + 1;
  localparam int PROD_W  = COEF_W + RATIO_W;
  localparam int RND_SH  = COEF_FRAC + RATIO_FRAC_BITS - ANGLE_FRAC;
  localparam int POLY_W  = ANGLE_W - 1;

  localparam logic [COEF_W-1:0] C1_Q30 = COEF_W'(1044100225);
  localparam logic [COEF_W-1:0] C2_Q30 = COEF_W'(206102542);

  localparam logic signed [ANGLE_W:0] PI_Q13      = (ANGLE_W+1)'(25736);
  localparam logic signed [ANGLE_W:0] HALF_PI_Q13 = (ANGLE_W+1)'(12868);

  // input register, one divider stage per quotient bit, four poly stages, output
  localparam int LATENCY = RATIO_FRAC_BITS + 7;

  typedef enum logic [2:0] {
    BR_ZERO,
    BR_XZ_POS,
    BR_XZ_NEG,
    BR_XDOM,
    BR_YDOM
  } branch_t;

  typedef struct packed {
    logic    vld;
    branch_t br;
    logic    zneg;
    logic    xn;
    logic    yn;
  } side_t;

endpackage

### hdl/atan2_polynomial_approx_unit.sv
// A start passes the input, divider, poly and output registers to out_valid.
// Throughput: one beat per cycle; busy stays low, the pipeline never stalls.
// Depth is set by the restoring divider, one quotient bit per stage (16 stages).
// Reset (rst_n low, synchronous) clears every stage valid bit; data regs keep junk.
`include "atan2_polynomial_approx_unit_defines.svh"

module atan2_polynomial_approx_unit
  import a2p_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_WIDTH-1:0] in_y_coord,
  input  logic signed [COORD_WIDTH-1:0] in_x_coord,
  output logic                      out_valid,
  output logic signed [ANGLE_W-1:0] out_angle
);

  localparam int F = RATIO_FRAC_BITS;

  // ---------------- input stage ----------------
  logic             yn, xn;
  logic [MAG_W-1:0] ym, xm;
  side_t            s0_sb_nxt, s0_sb_r;
  logic [MAG_W-1:0] s0_num_nxt, s0_num_r, s0_den_nxt, s0_den_r;

  assign busy = 1'b0;

  always_comb begin
    yn = in_y_coord[COORD_WIDTH-1];
    xn = in_x_coord[COORD_WIDTH-1];
    ym = yn ? MAG_W'(-in_y_coord) : MAG_W'(in_y_coord);
    xm = xn ? MAG_W'(-in_x_coord) : MAG_W'(in_x_coord);
    s0_sb_nxt.vld  = start;
    s0_sb_nxt.xn   = xn;
    s0_sb_nxt.yn   = yn;
    s0_sb_nxt.zneg = yn ^ xn;
    s0_num_nxt     = xm;
    s0_den_nxt     = ym;
    if (xm == '0) begin
      if (ym == '0) begin
        s0_sb_nxt.br = BR_ZERO;
      end else if (yn) begin
        s0_sb_nxt.br = BR_XZ_NEG;
      end else begin
        s0_sb_nxt.br = BR_XZ_POS;
      end
    end else if (xm > ym) begin
      s0_sb_nxt.br   = BR_XDOM;
      s0_sb_nxt.zneg = (ym != '0) && (yn ^ xn);
      s0_num_nxt     = ym;
      s0_den_nxt     = xm;
    end else begin
      s0_sb_nxt.br = BR_YDOM;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_sb_r.vld <= 1'b0;
    end else begin
      s0_sb_r.vld <= s0_sb_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    s0_sb_r.br   <= s0_sb_nxt.br;
    s0_sb_r.zneg <= s0_sb_nxt.zneg;
    s0_sb_r.xn   <= s0_sb_nxt.xn;
    s0_sb_r.yn   <= s0_sb_nxt.yn;
    s0_num_r     <= s0_num_nxt;
    s0_den_r     <= s0_den_nxt;
  end

  // ---------------- restoring divider, one quotient bit per stage ----------------
  side_t              dv_sb_r  [0:F];
  logic [MAG_W-1:0]   dv_rem_r [0:F];
  logic [MAG_W-1:0]   dv_den_r [0:F];
  logic [RATIO_W-1:0] dv_q_r   [0:F];

  for (genvar j = 0; j <= F; j++) begin : g_div
    side_t              sb_in;
    logic [MAG_W-1:0]   rem_in, den_in;
    logic [RATIO_W-1:0] q_in;
    logic [MAG_W:0]     shifted, trial;
    logic               take;

    if (j == 0) begin : g_first
      always_comb begin
        sb_in   = s0_sb_r;
        rem_in  = s0_num_r;
        den_in  = s0_den_r;
        q_in    = '0;
        shifted = {1'b0, rem_in};
      end
    end else begin : g_next
      always_comb begin
        sb_in   = dv_sb_r[j-1];
        rem_in  = dv_rem_r[j-1];
        den_in  = dv_den_r[j-1];
        q_in    = dv_q_r[j-1];
        shifted = {rem_in, 1'b0};
      end
    end

    always_comb begin
      trial = shifted - {1'b0, den_in};
      take  = !trial[MAG_W];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_sb_r[j].vld <= 1'b0;
      end else begin
        dv_sb_r[j].vld <= sb_in.vld;
      end
    end

    always_ff @(posedge clk) begin
      dv_sb_r[j].br   <= sb_in.br;
      dv_sb_r[j].zneg <= sb_in.zneg;
      dv_sb_r[j].xn   <= sb_in.xn;
      dv_sb_r[j].yn   <= sb_in.yn;
      dv_rem_r[j]     <= take ? trial[MAG_W-1:0] : shifted[MAG_W-1:0];
      dv_den_r[j]     <= den_in;
      dv_q_r[j]       <= {q_in[RATIO_W-2:0], take};
    end
  end

  // ---------------- polynomial ----------------
  side_t              sq_sb_r, tm_sb_r, in_sb_r, pp_sb_r;
  logic [RATIO_W-1:0] sq_m_r, tm_m_r, in_m_r;
  logic [RATIO_W-1:0] sq_m2_r;
  logic [COEF_W-1:0]  tm_t_r, in_inner_r;
  logic [PROD_W-1:0]  pp_p_r;

  logic [2*RATIO_W-1:0]    sq_prod;
  logic [COEF_W+RATIO_W-1:0] t_prod;

  assign sq_prod = (2*RATIO_W)'(dv_q_r[F]) * (2*RATIO_W)'(dv_q_r[F]);
  assign t_prod  = PROD_W'(C2_Q30) * PROD_W'(sq_m2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_sb_r.vld <= 1'b0;
      tm_sb_r.vld <= 1'b0;
      in_sb_r.vld <= 1'b0;
      pp_sb_r.vld <= 1'b0;
    end else begin
      sq_sb_r.vld <= dv_sb_r[F].vld;
      tm_sb_r.vld <= sq_sb_r.vld;
      in_sb_r.vld <= tm_sb_r.vld;
      pp_sb_r.vld <= in_sb_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    {sq_sb_r.br, sq_sb_r.zneg, sq_sb_r.xn, sq_sb_r.yn} <=
      {dv_sb_r[F].br, dv_sb_r[F].zneg, dv_sb_r[F].xn, dv_sb_r[F].yn};
    {tm_sb_r.br, tm_sb_r.zneg, tm_sb_r.xn, tm_sb_r.yn} <=
      {sq_sb_r.br, sq_sb_r.zneg, sq_sb_r.xn, sq_sb_r.yn};
    {in_sb_r.br, in_sb_r.zneg, in_sb_r.xn, in_sb_r.yn} <=
      {tm_sb_r.br, tm_sb_r.zneg, tm_sb_r.xn, tm_sb_r.yn};
    {pp_sb_r.br, pp_sb_r.zneg, pp_sb_r.xn, pp_sb_r.yn} <=
      {in_sb_r.br, in_sb_r.zneg, in_sb_r.xn, in_sb_r.yn};
    sq_m_r     <= dv_q_r[F];
    sq_m2_r    <= sq_prod[2*F:F];
    tm_m_r     <= sq_m_r;
    tm_t_r     <= t_prod[F +: COEF_W];
    in_m_r     <= tm_m_r;
    in_inner_r <= C1_Q30 - tm_t_r;
    pp_p_r     <= PROD_W'(in_inner_r) * PROD_W'(in_m_r);
  end

  // ---------------- round, sign and quadrant offset ----------------
  logic [PROD_W:0]            rnd_sum;
  logic signed [ANGLE_W:0]    mag_s, a_s, ang_nxt;
  logic                       out_valid_r;
  logic signed [ANGLE_W-1:0]  out_angle_r;

  always_comb begin
    rnd_sum = {1'b0, pp_p_r} + ((PROD_W+1)'(1) << (RND_SH - 1));
    mag_s   = signed'((ANGLE_W+1)'(rnd_sum[RND_SH +: POLY_W]));
    a_s     = pp_sb_r.zneg ? -mag_s : mag_s;
    unique case (pp_sb_r.br)
      BR_ZERO:   ang_nxt = '0;
      BR_XZ_POS: ang_nxt = HALF_PI_Q13;
      BR_XZ_NEG: ang_nxt = -HALF_PI_Q13;
      BR_XDOM: begin
        if (!pp_sb_r.xn) begin
          ang_nxt = a_s;
        end else if (!pp_sb_r.yn) begin
          ang_nxt = a_s + PI_Q13;
        end else begin
          ang_nxt = a_s - PI_Q13;
        end
      end
      BR_YDOM: begin
        if (!pp_sb_r.yn) begin
          ang_nxt = HALF_PI_Q13 - a_s;
        end else begin
          ang_nxt = -a_s - HALF_PI_Q13;
        end
      end
      default: ang_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= pp_sb_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    out_angle_r <= ang_nxt[ANGLE_W-1:0];
  end

  assign out_valid = out_valid_r;
  assign out_angle = out_angle_r;

  // ---------------- checks ----------------
  `A2P_CHK(a_angle_range, out_valid_r, (out_angle_r >= -$signed(PI_Q13[ANGLE_W-1:0])) && (out_angle_r <= $signed(PI_Q13[ANGLE_W-1:0])), "angle out of range")
  `A2P_CHK(a_fixed_latency, out_valid_r, $past(start, LATENCY), "result without matching start")
  `A2P_CHK(a_origin_zero, out_valid_r && $past(start && (in_x_coord == '0) && (in_y_coord == '0), LATENCY), out_angle_r == '0, "origin must give zero")
  `A2P_CHK_NXT(a_last_stage, pp_sb_r.vld, out_valid_r, "beat lost in last stage")

endmodule
